FILE: rtl/pesev_pkg.sv
`default_nettype none
package pesev_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_A,
      ST_POP_B,
      ST_LOAD_B,
      ST_EXEC,
      ST_DIV,
      ST_PUSH,
      ST_POP_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_payload_type;

   typedef struct packed {
      logic signed [7:0] result_value;
      status_type        status;
   } rsp_payload_type;

   typedef struct packed {
      logic              start;
      logic signed [7:0] dividend;
      logic signed [7:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [7:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/pesev_divider.sv
`default_nettype none
module pesev_divider
   import pesev_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic       neg_ff, neg_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] quo_ff, quo_in;
   logic [7:0] dsr_ff, dsr_in;
   logic [8:0] shifted;
   logic [8:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[7]};
      trial   = shifted - {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = div_req.dividend[7] ^ div_req.divisor[7];
         quo_in  = div_req.dividend[7] ? 8'(-div_req.dividend) : div_req.dividend;
         dsr_in  = div_req.divisor[7] ? 8'(-div_req.divisor) : div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[8]) begin
            rem_in = trial[7:0];
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = shifted[7:0];
            quo_in = {quo_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? 8'(-quo_ff) : quo_ff;

   // A new division must never be started while one is still in progress.
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // The sequencer resolves division by zero itself and never hands it over.
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> div_req.divisor != 8'sd0)
      else $error("divider started with a zero divisor");

   // Completion follows the final busy step, with the step counter at its last value.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(cnt_ff) == 3'd7)
      else $error("divider completion without a final step");

endmodule
`default_nettype wire

FILE: rtl/prefix_expression_stack_evaluator_core.sv
`default_nettype none
// Digit transaction: the digit is pushed. Operator +, - or *: two stack pops through the
// registered memory read port followed by one arithmetic step and the push. Operator /:
// the same, with the quotient from the one-bit-per-cycle divider for a nonzero divisor.
// End transaction: one pop, then the result is registered once the output is free.
// One transaction is processed at a time; other symbols are accepted and ignored.
// Synchronous reset empties the stack and clears the error; stack memory is not cleared.
module prefix_expression_stack_evaluator_core
   import pesev_pkg::*;
#(
   parameter int STACK_DEPTH = 128
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  req_payload_type req_payload,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W   = $clog2(STACK_DEPTH);

   state_type             state_ff, state_in;
   logic [DEPTH_W-1:0]    depth_ff, depth_in;
   status_type            err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;
   op_type                op_ff, op_in;
   logic signed [7:0]     a_ff, a_in;
   logic signed [7:0]     b_ff, b_in;
   logic [7:0]            push_ff, push_in;
   logic                  pop_empty_ff, pop_empty_in;

   logic [7:0]            stack_mem [STACK_DEPTH];
   logic [7:0]            rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  rd_en;
   logic                  wr_en;

   logic                  req_fire;
   logic                  is_digit;
   logic                  is_op;
   logic                  stack_full;
   logic                  stack_empty;
   logic [DEPTH_W-1:0]    depth_dec;
   logic [7:0]            operand;
   logic signed [15:0]    product;
   logic                  emit_ok;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   pesev_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire    = req_valid && req_ready;
   assign is_digit    = (req_payload.symbol >= CHAR_ZERO) && (req_payload.symbol <= CHAR_NINE);
   assign is_op       = (req_payload.symbol == CHAR_PLUS) || (req_payload.symbol == CHAR_MINUS) ||
                        (req_payload.symbol == CHAR_STAR) || (req_payload.symbol == CHAR_SLASH);
   assign stack_full  = depth_ff == DEPTH_W'(STACK_DEPTH);
   assign stack_empty = depth_ff == '0;
   assign depth_dec   = depth_ff - DEPTH_W'(1);
   assign rd_addr     = depth_dec[IDX_W-1:0];
   assign operand     = pop_empty_ff ? 8'd0 : rd_data_ff;
   assign product     = a_ff * b_ff;
   assign emit_ok     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_payload.end_of_expr) begin
                  state_in = ST_POP_END;
               end else if (is_digit) begin
                  state_in = ST_PUSH;
               end else if (is_op) begin
                  state_in = ST_POP_A;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP_A:   state_in = ST_POP_B;
         ST_POP_B:   state_in = ST_LOAD_B;
         ST_LOAD_B:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (op_ff == OP_DIV && b_ff != 8'sd0) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH:    state_in = ST_IDLE;
         ST_POP_END: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      depth_in         = depth_ff;
      err_in           = err_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      op_in            = op_ff;
      a_in             = a_ff;
      b_in             = b_ff;
      push_in          = push_ff;
      pop_empty_in     = pop_empty_ff;
      rd_en            = 1'b0;
      wr_en            = 1'b0;
      req_ready        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = a_ff;
      div_req.divisor  = b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            push_in   = req_payload.symbol - CHAR_ZERO;
            unique case (req_payload.symbol)
               CHAR_PLUS:  op_in = OP_ADD;
               CHAR_MINUS: op_in = OP_SUB;
               CHAR_STAR:  op_in = OP_MUL;
               default:    op_in = OP_DIV;
            endcase
         end
         ST_POP_A, ST_POP_B, ST_POP_END: begin
            if (state_ff == ST_POP_B) begin
               a_in = operand;
            end
            rd_en        = 1'b1;
            pop_empty_in = stack_empty;
            if (stack_empty) begin
               if (err_ff == STATUS_OK) begin
                  err_in = STATUS_UNDERFLOW;
               end
            end else begin
               depth_in = depth_dec;
            end
         end
         ST_LOAD_B: begin
            b_in = operand;
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_ADD: push_in = 8'(a_ff + b_ff);
               OP_SUB: push_in = 8'(a_ff - b_ff);
               OP_MUL: push_in = product[7:0];
               OP_DIV: begin
                  push_in = 8'd0;
                  if (b_ff == 8'sd0) begin
                     if (err_ff == STATUS_OK) begin
                        err_in = STATUS_DIV_ZERO;
                     end
                  end else begin
                     div_req.start = 1'b1;
                  end
               end
               default: push_in = 8'd0;
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               push_in = div_rsp.quotient;
            end
         end
         ST_PUSH: begin
            if (stack_full) begin
               if (err_ff == STATUS_OK) begin
                  err_in = STATUS_OVERFLOW;
               end
            end else begin
               wr_en    = 1'b1;
               depth_in = depth_ff + DEPTH_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = operand;
               rsp_in.status       = err_ff;
               depth_in            = '0;
               err_in              = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff       <= rsp_in;
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      push_ff      <= push_in;
      pop_empty_ff <= pop_empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[depth_ff[IDX_W-1:0]] <= push_ff;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The stack pointer never runs past the configured depth.
   assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= STACK_DEPTH)
      else $error("stack depth beyond capacity");

   // A new result only appears after the emit step of an end transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

   // The sequencer only waits on the divider after having started it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ($past(state_ff == ST_EXEC) || $past(state_ff == ST_DIV)))
      else $error("divider wait entered without a start");

endmodule
`default_nettype wire

FILE: tb/tb_prefix_expression_stack_evaluator_core.sv
`default_nettype none
module tb_prefix_expression_stack_evaluator_core;
   import pesev_pkg::*;

   localparam int STACK_DEPTH = 128;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      req_payload_type item;
      logic            known;
      rsp_payload_type answer;
   } script_row_type;

   localparam logic [7:0] OP_CHARS [4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};

   // Rows with known set carry an answer that is plain from the expression itself.
   localparam script_row_type SCRIPT [27] = '{
      '{'{8'h00, 1'b1}, 1'b1, '{8'sd0, STATUS_UNDERFLOW}},
      '{'{CHAR_ZERO + 8'd9, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{8'h00, 1'b1}, 1'b1, '{8'sd9, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd3, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd4, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_PLUS, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd2, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_MINUS, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{8'hFF, 1'b1}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd7, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_SLASH, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd9, 1'b1}, 1'b1, '{8'sd0, STATUS_DIV_ZERO}},
      '{'{8'h61, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{8'hFF, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_PLUS, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd7, 1'b1}, 1'b1, '{8'sd0, STATUS_UNDERFLOW}},
      '{'{CHAR_ZERO + 8'd1, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_MINUS, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd4, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd4, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_STAR, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_ZERO + 8'd8, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_STAR, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_SLASH, 1'b0}, 1'b0, '{8'sd0, STATUS_OK}},
      '{'{CHAR_SLASH, 1'b1}, 1'b1, '{8'sh80, STATUS_OK}}
   };

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   logic [7:0]      operand_mem [STACK_DEPTH];
   int              held_count = 0;
   status_type      held_error = STATUS_OK;
   rsp_payload_type expected_results [$];
   rsp_payload_type oldest_result;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              items_sent = 0;

   prefix_expression_stack_evaluator_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit take_break();
      if (cycle_count >= 2000 && cycle_count < 5000)
         return 1'b0;
      return $urandom_range(99) < 8;
   endfunction

   function automatic void note_fault(input status_type code);
      if (held_error == STATUS_OK)
         held_error = code;
   endfunction

   function automatic void push_operand(input logic [7:0] value);
      if (held_count >= STACK_DEPTH) begin
         note_fault(STATUS_OVERFLOW);
      end else begin
         operand_mem[held_count] = value;
         held_count++;
      end
   endfunction

   function automatic logic signed [7:0] pop_operand();
      if (held_count == 0) begin
         note_fault(STATUS_UNDERFLOW);
         return 8'sd0;
      end
      held_count--;
      return operand_mem[held_count];
   endfunction

   task automatic evaluate_symbol(input req_payload_type item, output bit emits,
                                  output rsp_payload_type outcome);
      int lhs;
      int rhs;
      int acc;
      emits = 1'b0;
      outcome = '0;
      if (item.end_of_expr) begin
         outcome.result_value = pop_operand();
         outcome.status = held_error;
         held_count = 0;
         held_error = STATUS_OK;
         emits = 1'b1;
      end else if (item.symbol >= CHAR_ZERO && item.symbol <= CHAR_NINE) begin
         push_operand(item.symbol - CHAR_ZERO);
      end else if (item.symbol == CHAR_PLUS || item.symbol == CHAR_MINUS ||
                   item.symbol == CHAR_STAR || item.symbol == CHAR_SLASH) begin
         lhs = pop_operand();
         rhs = pop_operand();
         case (item.symbol)
            CHAR_PLUS: acc = lhs + rhs;
            CHAR_MINUS: acc = lhs - rhs;
            CHAR_STAR: acc = lhs * rhs;
            default: begin
               if (rhs == 0) begin
                  note_fault(STATUS_DIV_ZERO);
                  acc = 0;
               end else begin
                  acc = lhs / rhs;
               end
            end
         endcase
         push_operand(acc[7:0]);
      end
   endtask

   task automatic send_item(input req_payload_type item, input bit known,
                            input rsp_payload_type answer);
      bit              emits;
      rsp_payload_type predicted;
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      evaluate_symbol(item, emits, predicted);
      if (emits)
         expected_results.push_back(known ? answer : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_symbol(input logic [7:0] symbol, input logic last);
      req_payload_type item;
      item.symbol = symbol;
      item.end_of_expr = last;
      send_item(item, 1'b0, '0);
   endtask

   always @(negedge clock) begin
      rsp_ready <= !take_break();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_prefix_expression_stack_evaluator_core failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none outstanding, got value %0d status %0d",
                     $time, rsp_payload.result_value, rsp_payload.status);
            mismatch_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_payload.result_value !== oldest_result.result_value) begin
               $display("%0t: result_value expected %0d, got %0d", $time,
                        oldest_result.result_value, rsp_payload.result_value);
               mismatch_count++;
            end
            if (rsp_payload.status !== oldest_result.status) begin
               $display("%0t: status expected %0d, got %0d", $time,
                        oldest_result.status, rsp_payload.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int  expr_index;
      int  operands_left;
      int  depth_now;
      int  fault_kind;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i])
         send_item(SCRIPT[i].item, SCRIPT[i].known, SCRIPT[i].answer);

      expr_index = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         expr_index++;
         if (expr_index == 7 || expr_index == 40) begin
            // A flood of 127 to 136 digits that runs the stack near, up to or past full depth.
            repeat ($urandom_range(136, 127))
               send_symbol(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
            repeat ($urandom_range(3))
               send_symbol(OP_CHARS[$urandom_range(3)], 1'b0);
         end else begin
            operands_left = $urandom_range(8, 1);
            depth_now = 0;
            fault_kind = $urandom_range(9);
            if (fault_kind == 0)
               send_symbol(OP_CHARS[$urandom_range(3)], 1'b0);
            while (operands_left > 0 || (depth_now > 1 && fault_kind != 1)) begin
               if ($urandom_range(99) < 5)
                  send_symbol(8'($urandom_range(255)), 1'b0);
               if (depth_now >= 2 && (operands_left == 0 || $urandom_range(1) == 1)) begin
                  send_symbol(OP_CHARS[$urandom_range(3)], 1'b0);
                  depth_now--;
               end else begin
                  send_symbol(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
                  operands_left--;
                  depth_now++;
               end
            end
         end
         send_symbol(8'($urandom_range(255)), 1'b1);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_prefix_expression_stack_evaluator_core passed");
      else
         $display("tb_prefix_expression_stack_evaluator_core failed");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/pesev_pkg.sv
rtl/pesev_divider.sv
rtl/prefix_expression_stack_evaluator_core.sv
tb/tb_prefix_expression_stack_evaluator_core.sv
